/* rtl/xmodem_block_receiver_assert.svh */
// assertion macros shared by the xmodem receiver checker
`ifndef XMODEM_BLOCK_RECEIVER_ASSERT_SVH
`define XMODEM_BLOCK_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define XBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xbr assertion failed");

// next-cycle implication, disabled during reset
`define XBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xbr assertion failed");

`endif

/* rtl/xbr_pkg.sv */
// types, codes and helper functions of the xmodem block receiver
package xbr_pkg;

  // request types
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // verdict codes
  localparam logic [2:0] VERDICT_COMMIT = 3'd0;
  localparam logic [2:0] VERDICT_BAD    = 3'd1;
  localparam logic [2:0] VERDICT_DUP    = 3'd2;

  // end codes
  localparam logic [2:0] END_OK        = 3'd0;
  localparam logic [2:0] END_CANCELLED = 3'd1;
  localparam logic [2:0] END_ERROR     = 3'd2;
  localparam logic [2:0] END_RETRIES   = 3'd3;
  localparam logic [2:0] END_SILENT    = 3'd4;
  localparam logic [2:0] CODE_NONE     = 3'd0;

  // line bytes
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CH_POLL = 8'h43;
  localparam logic [7:0] CH_TIMEOUT = 8'hFF;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT     = 1'b0;
  localparam logic CFG_HANDSHAKE_TRIES = 1'b1;

  localparam logic [7:0] RETRY_LIMIT_RESET     = 8'd10;
  localparam logic [7:0] HANDSHAKE_TRIES_RESET = 8'd16;

  localparam int unsigned IDX_W = 7;
  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HAND = 4'd1,
    PH_CMD  = 4'd2,
    PH_NUM  = 4'd3,
    PH_INV  = 4'd4,
    PH_DATA = 4'd5,
    PH_CHK1 = 4'd6,
    PH_CHK2 = 4'd7,
    PH_CAN2 = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] block_number;
    logic [2:0]  code;
    logic        last;
  } rsp_t;

  // one byte of crc-16 (poly 0x1021), msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // result item with last cleared
  function automatic rsp_t mk_rsp(input logic [1:0] kind, input logic [7:0] value,
                                  input logic [15:0] blk, input logic [2:0] code);
    rsp_t r;
    r.kind         = kind;
    r.value        = value;
    r.block_number = blk;
    r.code         = code;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/xmodem_block_receiver.sv */
// top level of the xmodem block receiver
//
//  channel | signals                          | direction
//  req     | req_valid, req_stall, req_item   | request items in
//  rsp     | rsp_valid, rsp_stall, rsp_item   | result items out
//  cfg     | cfg_we, cfg_index, cfg_data      | register writes in
//
// one result item leaves per cycle while rsp_stall is low; an item's results fill the
// four-entry result buffer until the last one leaves; an item with no result leaves it empty.
// an accepted item is held in the input register and then decoded into the result
// buffer, from which its first result shows.
// reset is synchronous and clears the phase, counters and both registers.
// a stalled result holds; the input register takes a new item while results wait.
module xmodem_block_receiver #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xbr_pkg::req_t req_item,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output xbr_pkg::rsp_t rsp_item,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);

  logic [7:0]    retry_limit;
  logic [7:0]    handshake_tries;
  logic          item_valid;
  xbr_pkg::req_t item;
  logic          take;
  logic          pop;
  logic          rbuf_free;
  xbr_pkg::rsp_t [xbr_pkg::MAX_RESULTS-1:0] list;
  logic [2:0]    count;
  xbr_pkg::rsp_t [xbr_pkg::MAX_RESULTS-1:0] rbuf;
  logic [1:0]    rbuf_rd;
  logic          rbuf_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit     <= xbr_pkg::RETRY_LIMIT_RESET;
      handshake_tries <= xbr_pkg::HANDSHAKE_TRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        xbr_pkg::CFG_RETRY_LIMIT:     retry_limit     <= cfg_data;
        xbr_pkg::CFG_HANDSHAKE_TRIES: handshake_tries <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake glue
  assign pop       = rsp_valid && !rsp_stall;
  assign rbuf_free = !rbuf_valid || (pop && rsp_item.last);
  assign take      = item_valid && rbuf_free;
  assign req_stall = item_valid && !take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req_item;
    end
  end

  xbr_engine #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .fire            (take),
    .item            (item),
    .retry_limit     (retry_limit),
    .handshake_tries (handshake_tries),
    .list            (list),
    .count           (count)
  );

  // result buffer, drained one transaction per cycle unless rsp_stall holds it
  always_ff @(posedge clk) begin
    if (rst) begin
      rbuf_valid <= 1'b0;
      rbuf_rd    <= 2'd0;
    end else if (take) begin
      rbuf_valid <= (count != 3'd0);
      rbuf_rd    <= 2'd0;
    end else if (pop) begin
      if (rsp_item.last) begin
        rbuf_valid <= 1'b0;
      end else begin
        rbuf_rd <= rbuf_rd + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rbuf <= list;
    end
  end

  assign rsp_valid = rbuf_valid;
  assign rsp_item  = rbuf[rbuf_rd];

endmodule

/* rtl/xbr_engine.sv */
// protocol state and per-item next-state and result logic
module xbr_engine #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     fire,
  input  xbr_pkg::req_t                            item,
  input  logic [7:0]                               retry_limit,
  input  logic [7:0]                               handshake_tries,
  output xbr_pkg::rsp_t [xbr_pkg::MAX_RESULTS-1:0] list,
  output logic [2:0]                               count
);

  xbr_pkg::phase_t         phase, phase_next;
  logic                    crc_mode, crc_mode_next;
  logic [7:0]              expected_block, expected_block_next;
  logic [15:0]             delivered_count, delivered_count_next;
  logic [7:0]              nak_count, nak_count_next;
  logic [8:0]              poll_count, poll_count_next;
  logic [xbr_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]             running_crc, running_crc_next;
  logic [7:0]              running_sum, running_sum_next;
  logic [7:0]              held_byte, held_byte_next;
  logic                    duplicate_flag, duplicate_flag_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= xbr_pkg::PH_IDLE;
      crc_mode        <= 1'b0;
      expected_block  <= 8'd1;
      delivered_count <= 16'd1;
      nak_count       <= 8'd0;
      poll_count      <= 9'd0;
      byte_index      <= '0;
      running_crc     <= 16'd0;
      running_sum     <= 8'd0;
      held_byte       <= 8'd0;
      duplicate_flag  <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      crc_mode        <= crc_mode_next;
      expected_block  <= expected_block_next;
      delivered_count <= delivered_count_next;
      nak_count       <= nak_count_next;
      poll_count      <= poll_count_next;
      byte_index      <= byte_index_next;
      running_crc     <= running_crc_next;
      running_sum     <= running_sum_next;
      held_byte       <= held_byte_next;
      duplicate_flag  <= duplicate_flag_next;
    end
  end

  // next state and results of one item
  always_comb begin
    logic        is_to;
    logic [7:0]  b;
    logic        do_poll, do_cmd, do_bad, do_rej, do_acc, do_pay, do_can_ok;
    logic        do_end;
    logic [2:0]  end_code;
    logic [15:0] cur;
    logic [8:0]  nk;
    logic [7:0]  nx;
    logic [2:0]  n;
    xbr_pkg::rsp_t [xbr_pkg::MAX_RESULTS-1:0] r;

    phase_next           = phase;
    crc_mode_next        = crc_mode;
    expected_block_next  = expected_block;
    delivered_count_next = delivered_count;
    nak_count_next       = nak_count;
    poll_count_next      = poll_count;
    byte_index_next      = byte_index;
    running_crc_next     = running_crc;
    running_sum_next     = running_sum;
    held_byte_next       = held_byte;
    duplicate_flag_next  = duplicate_flag;

    is_to     = (item.req_type == xbr_pkg::REQ_TIMEOUT);
    b         = is_to ? xbr_pkg::CH_TIMEOUT : item.rx_byte;
    do_poll   = 1'b0;
    do_cmd    = 1'b0;
    do_bad    = 1'b0;
    do_rej    = 1'b0;
    do_acc    = 1'b0;
    do_pay    = 1'b0;
    do_can_ok = 1'b0;
    do_end    = 1'b0;
    end_code  = xbr_pkg::CODE_NONE;
    nk        = {1'b0, nak_count} + 9'd1;
    nx        = {1'b0, byte_index} + 8'd1;
    n         = 3'd0;
    r         = '0;

    // decode the item against the phase
    case (item.req_type)
      xbr_pkg::REQ_START: begin
        crc_mode_next        = 1'b0;
        expected_block_next  = 8'd1;
        delivered_count_next = 16'd1;
        nak_count_next       = 8'd0;
        poll_count_next      = 9'd0;
        byte_index_next      = '0;
        running_crc_next     = 16'd0;
        running_sum_next     = 8'd0;
        held_byte_next       = 8'd0;
        duplicate_flag_next  = 1'b0;
        do_poll              = 1'b1;
      end
      xbr_pkg::REQ_BYTE, xbr_pkg::REQ_TIMEOUT: begin
        case (phase)
          xbr_pkg::PH_HAND: begin
            if (is_to) begin
              do_poll = 1'b1;
            end else begin
              do_cmd = 1'b1;
            end
          end
          xbr_pkg::PH_CMD: do_cmd = 1'b1;
          xbr_pkg::PH_CAN2: begin
            if (!is_to && b == xbr_pkg::CH_CAN) begin
              do_can_ok = 1'b1;
            end else begin
              do_bad = 1'b1;
            end
          end
          xbr_pkg::PH_NUM: begin
            held_byte_next = b;
            phase_next     = xbr_pkg::PH_INV;
          end
          xbr_pkg::PH_INV: begin
            if (b == ~held_byte && held_byte == expected_block - 8'd1) begin
              duplicate_flag_next = 1'b1;
              phase_next          = xbr_pkg::PH_DATA;
            end else if (b == ~held_byte && held_byte == expected_block) begin
              duplicate_flag_next = 1'b0;
              phase_next          = xbr_pkg::PH_DATA;
            end else begin
              duplicate_flag_next = 1'b0;
              do_rej              = 1'b1;
            end
          end
          xbr_pkg::PH_DATA: begin
            if (is_to) begin
              do_rej = 1'b1;
            end else begin
              do_pay           = 1'b1;
              running_crc_next = xbr_pkg::crc_byte(running_crc, b);
              running_sum_next = running_sum + b;
              byte_index_next  = nx[xbr_pkg::IDX_W-1:0];
              if (nx >= 8'(BLOCK_BYTES)) begin
                byte_index_next = '0;
                phase_next      = xbr_pkg::PH_CHK1;
              end
            end
          end
          xbr_pkg::PH_CHK1: begin
            if (crc_mode) begin
              held_byte_next = b;
              phase_next     = xbr_pkg::PH_CHK2;
            end else if (b == running_sum) begin
              do_acc = 1'b1;
            end else begin
              do_rej = 1'b1;
            end
          end
          xbr_pkg::PH_CHK2: begin
            if ({held_byte, b} == running_crc) begin
              do_acc = 1'b1;
            end else begin
              do_rej = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    cur = delivered_count - {15'd0, duplicate_flag_next};

    // handshake poll: 'C' first, then NAK, then give up
    if (do_poll) begin
      if (poll_count_next < {1'b0, handshake_tries}) begin
        crc_mode_next   = 1'b1;
        r[n[1:0]]       = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_POLL, 16'd0,
                                          xbr_pkg::CODE_NONE);
        n               = n + 3'd1;
        poll_count_next = poll_count_next + 9'd1;
        phase_next      = xbr_pkg::PH_HAND;
      end else if (poll_count_next < {handshake_tries, 1'b0}) begin
        crc_mode_next   = 1'b0;
        r[n[1:0]]       = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_NAK, 16'd0,
                                          xbr_pkg::CODE_NONE);
        n               = n + 3'd1;
        poll_count_next = poll_count_next + 9'd1;
        phase_next      = xbr_pkg::PH_HAND;
      end else begin
        do_end   = 1'b1;
        end_code = xbr_pkg::END_SILENT;
      end
    end

    // command byte
    if (do_cmd) begin
      if (!is_to && b == xbr_pkg::CH_SOH) begin
        byte_index_next     = '0;
        running_crc_next    = 16'd0;
        running_sum_next    = 8'd0;
        duplicate_flag_next = 1'b0;
        phase_next          = xbr_pkg::PH_NUM;
      end else if (!is_to && b == xbr_pkg::CH_EOT) begin
        r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_ACK, 16'd0,
                                    xbr_pkg::CODE_NONE);
        n         = n + 3'd1;
        do_end    = 1'b1;
        end_code  = xbr_pkg::END_OK;
      end else if (!is_to && b == xbr_pkg::CH_CAN) begin
        phase_next = xbr_pkg::PH_CAN2;
      end else begin
        do_bad = 1'b1;
      end
    end

    // second CAN confirms the cancel
    if (do_can_ok) begin
      r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_ACK, 16'd0,
                                  xbr_pkg::CODE_NONE);
      n         = n + 3'd1;
      do_end    = 1'b1;
      end_code  = xbr_pkg::END_CANCELLED;
    end

    // line error: three CANs
    if (do_bad) begin
      for (int i = 0; i < 3; i++) begin
        r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_CAN, 16'd0,
                                    xbr_pkg::CODE_NONE);
        n         = n + 3'd1;
      end
      do_end   = 1'b1;
      end_code = xbr_pkg::END_ERROR;
    end

    // tentative payload byte
    if (do_pay) begin
      r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_PAYLOAD, b, cur, xbr_pkg::CODE_NONE);
      n         = n + 3'd1;
    end

    // bad block: verdict, NAK, and maybe out of retries
    if (do_rej) begin
      r[n[1:0]]      = xbr_pkg::mk_rsp(xbr_pkg::KIND_VERDICT, 8'd0, cur, xbr_pkg::VERDICT_BAD);
      n              = n + 3'd1;
      r[n[1:0]]      = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_NAK, 16'd0,
                                       xbr_pkg::CODE_NONE);
      n              = n + 3'd1;
      nak_count_next = nk[8] ? 8'hFF : nk[7:0];
      if (nk < {1'b0, retry_limit}) begin
        phase_next = xbr_pkg::PH_CMD;
      end else begin
        do_end   = 1'b1;
        end_code = xbr_pkg::END_RETRIES;
      end
    end

    // good block: commit or duplicate, then ACK
    if (do_acc) begin
      if (duplicate_flag) begin
        r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_VERDICT, 8'd0, cur, xbr_pkg::VERDICT_DUP);
      end else begin
        r[n[1:0]] = xbr_pkg::mk_rsp(xbr_pkg::KIND_VERDICT, 8'd0, delivered_count,
                                    xbr_pkg::VERDICT_COMMIT);
        expected_block_next  = expected_block + 8'd1;
        delivered_count_next = delivered_count + 16'd1;
      end
      n          = n + 3'd1;
      r[n[1:0]]  = xbr_pkg::mk_rsp(xbr_pkg::KIND_SEND, xbr_pkg::CH_ACK, 16'd0,
                                   xbr_pkg::CODE_NONE);
      n          = n + 3'd1;
      phase_next = xbr_pkg::PH_CMD;
    end

    // transfer end
    if (do_end) begin
      r[n[1:0]]  = xbr_pkg::mk_rsp(xbr_pkg::KIND_END, 8'd0, 16'd0, end_code);
      n          = n + 3'd1;
      phase_next = xbr_pkg::PH_IDLE;
    end

    // mark the final result of the item
    if (n != 3'd0) begin
      r[2'(n - 3'd1)].last = 1'b1;
    end

    list  = r;
    count = n;
  end

endmodule

/* rtl/xbr_checker.sv */
// port-level checker for the xmodem block receiver, bound to the top level
`include "xmodem_block_receiver_assert.svh"

module xbr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input xbr_pkg::rsp_t rsp_item
);

  // a stalled result transaction holds
  `XBR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

  // nothing comes out and nothing is held off straight after reset
  `XBR_ASSERT_IMP(a_quiet_after_reset, $past(rst), !rsp_valid && !req_stall)

  // a transfer end is always the final result of its item
  `XBR_ASSERT_IMP(a_end_is_last, rsp_valid && rsp_item.kind == xbr_pkg::KIND_END, rsp_item.last)

  // verdicts carry a verdict code and no byte
  `XBR_ASSERT_IMP(a_verdict_fields, rsp_valid && rsp_item.kind == xbr_pkg::KIND_VERDICT, (rsp_item.code == xbr_pkg::VERDICT_COMMIT || rsp_item.code == xbr_pkg::VERDICT_BAD || rsp_item.code == xbr_pkg::VERDICT_DUP) && rsp_item.value == 8'd0)

  // bytes to send carry no block number and no code
  `XBR_ASSERT_IMP(a_send_fields, rsp_valid && rsp_item.kind == xbr_pkg::KIND_SEND, rsp_item.block_number == 16'd0 && rsp_item.code == xbr_pkg::CODE_NONE)

endmodule

bind xmodem_block_receiver xbr_checker u_xbr_checker (.*);
